// ===== rtl/palist_pkg.sv =====
package palist_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;

  // list geometry
  localparam int CAPACITY_DEF = 16;
  localparam int RUN_LIMIT    = 16;
  // compare width that holds any position and any count up to 256
  localparam int CMP_W        = 9;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command kinds as they arrive
  localparam logic [KIND_W-1:0] KIND_SEARCH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_ALL = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_KIND  = 3'd5
  } status_t;

  // decoded operation
  typedef enum logic [2:0] {
    OP_SEARCH,
    OP_INSERT,
    OP_DELETE,
    OP_UPDATE,
    OP_READ_ALL,
    OP_BAD_KIND
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } cmd_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic [CMP_W-1:0] count;
    logic             in_run;
  } back_stat_t;

endpackage

// ===== rtl/palist_if.sv =====
interface palist_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [palist_pkg::KIND_W-1:0]          kind;
  logic signed [palist_pkg::DATA_W-1:0]   data_value;
  logic [palist_pkg::POS_W-1:0]           position;

  modport source (output valid, output kind, output data_value, output position,
                  input ready);
  modport sink (input valid, input kind, input data_value, input position,
                output ready);
endinterface

interface palist_res_if;
  logic                                   valid;
  logic                                   ready;
  logic [palist_pkg::STATUS_W-1:0]        status;
  logic [palist_pkg::INDEX_W-1:0]         entry_index;
  logic signed [palist_pkg::DATA_W-1:0]   entry_value;
  logic [palist_pkg::COUNT_W-1:0]         entry_count;
  logic                                   last;

  modport source (output valid, output status, output entry_index, output entry_value,
                  output entry_count, output last, input ready);
  modport sink (input valid, input status, input entry_index, input entry_value,
                input entry_count, input last, output ready);
endinterface

// ===== rtl/palist_front.sv =====
module palist_front (
  input  logic                clk,
  input  logic                rst,
  palist_cmd_if.sink          cmd,
  output logic                q_valid,
  output palist_pkg::cmd_t    q_cmd,
  input  logic                q_ready
);

  logic             held;
  palist_pkg::cmd_t held_cmd;
  palist_pkg::cmd_t dec_cmd;

  // decode the kind field
  always_comb begin
    dec_cmd.value    = cmd.data_value;
    dec_cmd.position = cmd.position;
    case (cmd.kind)
      palist_pkg::KIND_SEARCH:   dec_cmd.op = palist_pkg::OP_SEARCH;
      palist_pkg::KIND_INSERT:   dec_cmd.op = palist_pkg::OP_INSERT;
      palist_pkg::KIND_DELETE:   dec_cmd.op = palist_pkg::OP_DELETE;
      palist_pkg::KIND_UPDATE:   dec_cmd.op = palist_pkg::OP_UPDATE;
      palist_pkg::KIND_READ_ALL: dec_cmd.op = palist_pkg::OP_READ_ALL;
      default:                   dec_cmd.op = palist_pkg::OP_BAD_KIND;
    endcase
  end

  assign cmd.ready = !held || q_ready;

  // one-word holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd.ready) begin
      held <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      held_cmd <= dec_cmd;
    end
  end

  assign q_valid = held;
  assign q_cmd   = held_cmd;

endmodule

// ===== rtl/palist_fifo.sv =====
module palist_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  palist_pkg::cmd_t    in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  output palist_pkg::cmd_t    out_cmd,
  input  logic                out_ready
);

  palist_pkg::cmd_t                 mem [palist_pkg::QUEUE_DEPTH];
  logic [palist_pkg::QPTR_W-1:0]    wr_ptr;
  logic [palist_pkg::QPTR_W-1:0]    rd_ptr;
  logic [palist_pkg::QCNT_W-1:0]    fill;
  logic                             push;
  logic                             pop;

  assign in_ready  = fill != palist_pkg::QCNT_W'(palist_pkg::QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/palist_back.sv =====
module palist_back #(
  parameter int CAPACITY = palist_pkg::CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  palist_pkg::cmd_t        q_cmd,
  output logic                    q_ready,
  palist_res_if.source            res,
  output palist_pkg::back_stat_t  stat
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = palist_pkg::DATA_W;
  localparam int XW = palist_pkg::CMP_W;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'b001,
    BK_SEARCH = 3'b010,
    BK_RUN    = 3'b100
  } bk_state_t;

  bk_state_t               state;
  bk_state_t               state_next;
  logic signed [DW-1:0]    entries [CAPACITY];
  logic signed [DW-1:0]    ent_next [CAPACITY];
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CAPACITY-1:0]     match;
  logic [CAPACITY-1:0]     match_next;
  logic [IW-1:0]           rd_idx;
  logic [IW-1:0]           run_end;

  logic                    out_valid;
  logic                    out_free;
  logic                    take;
  logic                    load;
  logic [XW-1:0]           n_cmp;
  logic [XW-1:0]           p_cmp;
  logic [XW-1:0]           n_last;
  logic                    full;
  logic                    ins_ok;
  logic                    pos_ok;
  logic                    wr_ins;
  logic                    wr_del;
  logic                    wr_upd;
  logic                    found;
  logic [IW-1:0]           found_idx;
  logic [IW-1:0]           run_end_next;

  palist_pkg::status_t     r_status;
  logic [IW-1:0]           r_index;
  logic signed [DW-1:0]    r_value;
  logic                    r_last;

  // command checks against the current count
  assign out_free = !out_valid || res.ready;
  assign q_ready  = (state == BK_IDLE) && out_free;
  assign take     = q_valid && q_ready;
  assign n_cmp    = XW'(count);
  assign p_cmp    = XW'(q_cmd.position);
  assign n_last   = n_cmp - XW'(1);
  assign full     = n_cmp >= XW'(CAPACITY);
  assign ins_ok   = !full && (p_cmp <= n_cmp);
  assign pos_ok   = p_cmp < n_cmp;
  assign wr_ins   = take && (q_cmd.op == palist_pkg::OP_INSERT) && ins_ok;
  assign wr_del   = take && (q_cmd.op == palist_pkg::OP_DELETE) && pos_ok;
  assign wr_upd   = take && (q_cmd.op == palist_pkg::OP_UPDATE) && pos_ok;

  always_comb begin
    count_next = count;
    if (wr_ins) begin
      count_next = count + 1'b1;
    end else if (wr_del) begin
      count_next = count - 1'b1;
    end
  end

  // per-entry shift, write and compare
  for (genvar i = 0; i < CAPACITY; i++) begin : g_ent
    localparam logic [XW-1:0] IC = XW'(i);
    logic signed [DW-1:0] up_src;
    logic signed [DW-1:0] dn_src;

    if (i == 0) begin : g_first
      assign up_src = entries[i];
    end else begin : g_up
      assign up_src = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign dn_src = entries[i];
    end else begin : g_dn
      assign dn_src = entries[i+1];
    end

    assign ent_next[i] =
      ((wr_ins || wr_upd) && (IC == p_cmp))           ? q_cmd.value :
      (wr_ins && (IC > p_cmp) && (IC <= n_cmp))       ? up_src :
      (wr_del && (IC >= p_cmp) && (IC < n_last))      ? dn_src :
                                                        entries[i];

    assign match_next[i] = (entries[i] == q_cmd.value) && (IC < n_cmp);
  end

  always_ff @(posedge clk) begin
    entries <= ent_next;
  end

  // first matching entry
  assign found = |match;
  always_comb begin
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = IW'(i);
      end
    end
  end

  // length of a read-all run, less one
  always_comb begin
    if (n_cmp > XW'(palist_pkg::RUN_LIMIT)) begin
      run_end_next = IW'(palist_pkg::RUN_LIMIT - 1);
    end else begin
      run_end_next = IW'(n_last);
    end
  end

  // sequencer and result selection
  always_comb begin
    state_next = state;
    load       = 1'b0;
    r_status   = palist_pkg::ST_OK;
    r_index    = '0;
    r_value    = '0;
    r_last     = 1'b1;
    case (state)
      BK_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            palist_pkg::OP_SEARCH: begin
              state_next = BK_SEARCH;
            end
            palist_pkg::OP_INSERT: begin
              load = 1'b1;
              if (full) begin
                r_status = palist_pkg::ST_FULL;
              end else if (!ins_ok) begin
                r_status = palist_pkg::ST_BAD_POS;
              end
            end
            palist_pkg::OP_DELETE, palist_pkg::OP_UPDATE: begin
              load = 1'b1;
              if (!pos_ok) begin
                r_status = palist_pkg::ST_BAD_POS;
              end
            end
            palist_pkg::OP_READ_ALL: begin
              if (count == '0) begin
                load     = 1'b1;
                r_status = palist_pkg::ST_EMPTY;
              end else begin
                state_next = BK_RUN;
              end
            end
            default: begin
              load     = 1'b1;
              r_status = palist_pkg::ST_BAD_KIND;
            end
          endcase
        end
      end
      BK_SEARCH: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = BK_IDLE;
          if (found) begin
            r_index = found_idx;
          end else begin
            r_status = palist_pkg::ST_NOT_FOUND;
          end
        end
      end
      BK_RUN: begin
        if (out_free) begin
          load    = 1'b1;
          r_index = rd_idx;
          r_value = entries[rd_idx];
          r_last  = rd_idx == run_end;
          if (r_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search vector and run pointer
  always_ff @(posedge clk) begin
    if (take && (q_cmd.op == palist_pkg::OP_SEARCH)) begin
      match <= match_next;
    end
    if (take && (q_cmd.op == palist_pkg::OP_READ_ALL)) begin
      rd_idx  <= '0;
      run_end <= run_end_next;
    end else if ((state == BK_RUN) && out_free) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      res.status      <= r_status;
      res.entry_index <= palist_pkg::INDEX_W'(r_index);
      res.entry_value <= r_value;
      res.entry_count <= palist_pkg::COUNT_W'(count_next);
      res.last        <= r_last;
    end
  end

  assign res.valid   = out_valid;
  assign stat.count  = XW'(count);
  assign stat.in_run = state == BK_RUN;

endmodule

// ===== rtl/positional_array_list_engine.sv =====
// A command passes the front holding register and the command queue; its result word
// is registered in the back end. A search first registers the match vector, a read-all
// run first enters its run state. The back end takes one insert, delete, update or
// refused command per cycle while result words are taken; a search or a read-all run
// keeps it busy until done, and a run gives min(count, 16) words.
// Reset (rst, synchronous) empties the list and the command queue; entry storage
// itself is not cleared.
module positional_array_list_engine #(
  parameter int CAPACITY = palist_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  palist_cmd_if.sink    cmd,
  palist_res_if.source  res
);

  logic                    f_valid;
  palist_pkg::cmd_t        f_cmd;
  logic                    f_ready;
  logic                    q_valid;
  palist_pkg::cmd_t        q_cmd;
  logic                    q_ready;
  palist_pkg::back_stat_t  stat;

  // accept and decode
  palist_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (f_valid),
    .q_cmd   (f_cmd),
    .q_ready (f_ready)
  );

  // command queue
  palist_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  // list storage and execution
  palist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .res     (res),
    .stat    (stat)
  );

  // a waiting word always reports the count currently held
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.entry_count == palist_pkg::COUNT_W'(stat.count))
    else $error("result count differs from list count");

  // refused commands give a single zero-valued word
  a_refused_single: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status != palist_pkg::ST_OK)) |-> (res.last && (res.entry_value == '0)))
    else $error("refused command word not final or carries a value");

  // only a read-all run produces non-final words
  a_nonlast_in_run: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> stat.in_run)
    else $error("non-final word outside a read-all run");

  // no word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result word present after reset");

endmodule
